// ----- sv/tspfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed slot pool package
// Shared request and response types and the mode codes.
// ----------------------------------------------------------------------------
package tspfl_pkg;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic        [15:0] radius;
      logic        [15:0] lifetime;
      logic        [15:0] elapse;
      logic        [4:0]  slot_select;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic        [4:0]  slot_index;
      logic               any_active;
      logic               read_active;
      logic signed [15:0] read_x;
      logic signed [15:0] read_y;
      logic signed [15:0] read_z;
      logic        [15:0] read_radius;
      logic        [15:0] read_elapsed;
      logic        [15:0] read_lifetime;
   } rsp_type;

endpackage

// ----- sv/tspfl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tspfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/timed_slot_pool_free_list.sv -----
// Result strobe is registered: clear and a refused add set it from idle, add and
// read from their own state, tick after walking the slot memory a slot per cycle.
// One item at a time: busy stays high until the result strobe; the next item
// may be taken in the cycle that carries the strobe. The receiver cannot stall.
// Reset and clear need no clearing pass over the memories: slot and queue flags
// are flip-flops cleared at once.
// ----------------------------------------------------------------------------
// Timed slot pool with FIFO free list
// Slot contents and the free queue live in RAM; ticks age every live slot in turn.
// ----------------------------------------------------------------------------
module timed_slot_pool_free_list
   import tspfl_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDXW = $clog2(SLOTS);
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int SELW = (IDXW > 5) ? IDXW : 5;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [15:0] radius;
      logic [15:0] elapsed;
      logic [15:0] lifetime;
   } slot_word_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_TICK = 4'b0100,
      ST_READ = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0]     queue_written_ff, queue_written_in;
   logic [IDXW-1:0]      head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        active_ff, active_in;
   logic [IDXW-1:0]      scan_ff, scan_in;
   logic                 in_range_ff, in_range_in;
   req_type              item_ff, item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // memory ports
   logic                 slot_wr_en;
   logic [IDXW-1:0]      slot_wr_addr;
   slot_word_type        slot_wr_data;
   logic [IDXW-1:0]      slot_rd_addr;
   slot_word_type        slot_rd_data;
   logic                 queue_wr_en;
   logic [IDXW-1:0]      queue_wr_addr;
   logic [IDXW-1:0]      queue_rd_addr;
   logic [IDXW-1:0]      queue_rd_data;

   logic [CW:0]          tail_sum;
   logic [IDXW-1:0]      tail;
   logic [IDXW-1:0]      head_next;
   logic [16:0]          age_sum;
   logic [15:0]          age_sat;
   logic                 expire;
   logic [IDXW-1:0]      add_slot;
   logic [SELW-1:0]      add_slot_wide;
   logic [SELW-1:0]      sel_wide;

   tspfl_ram #(
      .WIDTH ($bits(slot_word_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   tspfl_ram #(
      .WIDTH (IDXW),
      .DEPTH (SLOTS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (queue_wr_en),
      .wr_addr (queue_wr_addr),
      .wr_data (scan_ff),
      .rd_addr (queue_rd_addr),
      .rd_data (queue_rd_data)
   );

   assign tail_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail      = (tail_sum >= (CW+1)'(SLOTS)) ? IDXW'(tail_sum - (CW+1)'(SLOTS))
                                                   : IDXW'(tail_sum);
   assign head_next = (head_ff == IDXW'(SLOTS - 1)) ? '0 : head_ff + 1'b1;

   assign age_sum = {1'b0, slot_rd_data.elapsed} + {1'b0, item_ff.elapse};
   assign age_sat = age_sum[16] ? 16'hFFFF : age_sum[15:0];
   assign expire  = (age_sat >= slot_rd_data.lifetime);

   // a queue entry never written since clear holds its own position
   assign add_slot      = queue_written_ff[head_ff] ? queue_rd_data : head_ff;
   assign add_slot_wide = SELW'(add_slot);
   assign sel_wide      = SELW'(req_data.slot_select);

   always_comb begin
      state_in         = state_ff;
      slot_valid_in    = slot_valid_ff;
      queue_written_in = queue_written_ff;
      head_in          = head_ff;
      count_in         = count_ff;
      active_in        = active_ff;
      scan_in          = scan_ff;
      in_range_in      = in_range_ff;
      item_in          = item_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = '0;

      slot_wr_en       = 1'b0;
      slot_wr_addr     = scan_ff;
      slot_wr_data     = slot_rd_data;
      slot_rd_addr     = scan_ff + 1'b1;
      queue_wr_en      = 1'b0;
      queue_wr_addr    = tail;
      queue_rd_addr    = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            slot_rd_addr = sel_wide[IDXW-1:0];
            if (start) begin
               item_in = req_data;
               unique case (req_data.mode)
                  MODE_ADD: begin
                     if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.any_active  = (active_ff != '0);
                     end else begin
                        state_in = ST_ADD;
                     end
                  end
                  MODE_TICK: begin
                     slot_rd_addr = '0;
                     scan_in      = '0;
                     state_in     = ST_TICK;
                  end
                  MODE_CLEAR: begin
                     slot_valid_in     = '0;
                     queue_written_in  = '0;
                     head_in           = '0;
                     count_in          = CW'(SLOTS);
                     active_in         = '0;
                     rsp_valid_in      = 1'b1;
                  end
                  MODE_READ: begin
                     scan_in     = sel_wide[IDXW-1:0];
                     in_range_in = (32'(req_data.slot_select) < 32'(SLOTS));
                     state_in    = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ADD: begin
            slot_wr_en             = 1'b1;
            slot_wr_addr           = add_slot;
            slot_wr_data.pos_x     = item_ff.pos_x;
            slot_wr_data.pos_y     = item_ff.pos_y;
            slot_wr_data.pos_z     = item_ff.pos_z;
            slot_wr_data.radius    = item_ff.radius;
            slot_wr_data.elapsed   = '0;
            slot_wr_data.lifetime  = item_ff.lifetime;
            slot_valid_in[add_slot] = 1'b1;
            active_in              = active_ff + 1'b1;
            head_in                = head_next;
            count_in               = count_ff - 1'b1;
            rsp_valid_in           = 1'b1;
            rsp_in.accepted        = 1'b1;
            rsp_in.slot_index      = add_slot_wide[4:0];
            rsp_in.any_active      = 1'b1;
            state_in               = ST_IDLE;
         end

         ST_TICK: begin
            if (slot_valid_ff[scan_ff]) begin
               if (expire) begin
                  // retire the slot and append it to the free queue
                  slot_valid_in[scan_ff]  = 1'b0;
                  active_in               = active_ff - 1'b1;
                  queue_wr_en             = 1'b1;
                  queue_written_in[tail]  = 1'b1;
                  count_in                = count_ff + 1'b1;
               end else begin
                  slot_wr_en           = 1'b1;
                  slot_wr_data.elapsed = age_sat;
               end
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IDXW'(SLOTS - 1)) begin
               rsp_valid_in      = 1'b1;
               rsp_in.any_active = (active_in != '0);
               state_in          = ST_IDLE;
            end
         end

         ST_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_in.any_active = (active_ff != '0);
            if (in_range_ff && slot_valid_ff[scan_ff]) begin
               rsp_in.read_active   = 1'b1;
               rsp_in.read_x        = slot_rd_data.pos_x;
               rsp_in.read_y        = slot_rd_data.pos_y;
               rsp_in.read_z        = slot_rd_data.pos_z;
               rsp_in.read_radius   = slot_rd_data.radius;
               rsp_in.read_elapsed  = slot_rd_data.elapsed;
               rsp_in.read_lifetime = slot_rd_data.lifetime;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_valid_ff    <= '0;
         queue_written_ff <= '0;
         head_ff          <= '0;
         count_ff         <= CW'(SLOTS);
         active_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         slot_valid_ff    <= slot_valid_in;
         queue_written_ff <= queue_written_in;
         head_ff          <= head_in;
         count_ff         <= count_in;
         active_ff        <= active_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      in_range_ff <= in_range_in;
      item_ff     <= item_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- test/timed_slot_pool_free_list_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool free list testbench
// A directed table and then random traffic go through the command port. Each
// result is checked field by field, against a checked row's values, else a pool predictor.
// ----------------------------------------------------------------------------
module timed_slot_pool_free_list_tb;
   import tspfl_pkg::*;

   localparam int SLOTS      = 32;
   localparam int CYCLE_CAP  = 400000;
   localparam int RAND_ITEMS = 1900;
   localparam int SETTLE     = SLOTS + 8;

   typedef struct packed {
      req_type item;
      int      reps;
      bit      checked;
      rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // predicted pool contents
   logic        pool_valid  [SLOTS];
   logic [15:0] pool_x      [SLOTS];
   logic [15:0] pool_y      [SLOTS];
   logic [15:0] pool_z      [SLOTS];
   logic [15:0] pool_radius [SLOTS];
   logic [15:0] pool_age    [SLOTS];
   logic [15:0] pool_life   [SLOTS];
   logic [4:0]  free_ring   [SLOTS];
   logic [4:0]  free_head;
   int          free_count;

   rsp_type      rsp_due [$];
   plan_row_type plan [$];
   rsp_type      want_rsp;
   int           fail_count  = 0;
   int           cycle_count = 0;

   timed_slot_pool_free_list #(.SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void wipe_slot(input int s);
      pool_valid[s]  = 1'b0;
      pool_x[s]      = '0;
      pool_y[s]      = '0;
      pool_z[s]      = '0;
      pool_radius[s] = '0;
      pool_age[s]    = '0;
      pool_life[s]   = '0;
   endfunction

   function automatic void refill_pool();
      for (int i = 0; i < SLOTS; i++) begin
         wipe_slot(i);
         free_ring[i] = i[4:0];
      end
      free_head  = '0;
      free_count = SLOTS;
   endfunction

   function automatic rsp_type predict_pool_rsp(input req_type r);
      rsp_type     o;
      logic [4:0]  s;
      logic [4:0]  tail;
      logic [16:0] sum;
      logic        live;
      o = '0;
      case (r.mode)
         MODE_ADD: begin
            if (free_count > 0) begin
               s = free_ring[free_head];
               free_head = free_head + 5'd1;
               free_count--;
               pool_valid[s]  = 1'b1;
               pool_x[s]      = r.pos_x;
               pool_y[s]      = r.pos_y;
               pool_z[s]      = r.pos_z;
               pool_radius[s] = r.radius;
               pool_life[s]   = r.lifetime;
               pool_age[s]    = '0;
               o.accepted     = 1'b1;
               o.slot_index   = s;
            end
         end
         MODE_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (pool_valid[i]) begin
                  sum = {1'b0, pool_age[i]} + {1'b0, r.elapse};
                  if (sum[16]) sum = 17'h0ffff;
                  pool_age[i] = sum[15:0];
                  // expired slots go back to the queue tail in ascending order
                  if (sum[15:0] >= pool_life[i]) begin
                     wipe_slot(i);
                     if (free_count < SLOTS) begin
                        tail = free_head + free_count[4:0];
                        free_ring[tail] = i[4:0];
                        free_count++;
                     end
                  end
               end
            end
         end
         MODE_CLEAR: refill_pool();
         default: begin
            s = r.slot_select;
            o.read_active   = pool_valid[s];
            o.read_x        = pool_x[s];
            o.read_y        = pool_y[s];
            o.read_z        = pool_z[s];
            o.read_radius   = pool_radius[s];
            o.read_elapsed  = pool_age[s];
            o.read_lifetime = pool_life[s];
         end
      endcase
      live = 1'b0;
      for (int i = 0; i < SLOTS; i++) live = live | pool_valid[i];
      o.any_active = live;
      return o;
   endfunction

   function automatic req_type mk_req(input mode_type m, input logic [15:0] x, y, z,
                                      input logic [15:0] rad, life, el,
                                      input logic [4:0] sel);
      req_type r;
      r.mode        = m;
      r.pos_x       = x;
      r.pos_y       = y;
      r.pos_z       = z;
      r.radius      = rad;
      r.lifetime    = life;
      r.elapse      = el;
      r.slot_select = sel;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic acc, input logic [4:0] idx,
                                      input logic live, act,
                                      input logic [15:0] x, y, z, rad, el, life);
      rsp_type o;
      o.accepted      = acc;
      o.slot_index    = idx;
      o.any_active    = live;
      o.read_active   = act;
      o.read_x        = x;
      o.read_y        = y;
      o.read_z        = z;
      o.read_radius   = rad;
      o.read_elapsed  = el;
      o.read_lifetime = life;
      return o;
   endfunction

   function automatic rsp_type quiet_rsp(input logic live);
      return mk_rsp(1'b0, 5'd0, live, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
   endfunction

   function automatic void plan_step(input req_type r, input int reps, input bit checked,
                                     input rsp_type want);
      plan_row_type row;
      row.item    = r;
      row.reps    = reps;
      row.checked = checked;
      row.want    = want;
      plan.insert(plan.size(), row);
   endfunction

   // mostly well-formed pool traffic: adds and reads dominate, ticks age
   // entries gradually, with occasional huge steps and clears
   function automatic req_type rand_item();
      req_type r;
      int      pick;
      int      roll;
      pick = $urandom_range(0, 99);
      r.pos_x       = 16'($urandom_range(0, 65535));
      r.pos_y       = 16'($urandom_range(0, 65535));
      r.pos_z       = 16'($urandom_range(0, 65535));
      r.radius      = 16'($urandom_range(0, 65535));
      r.slot_select = 5'($urandom_range(0, SLOTS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 10)      r.lifetime = 16'($urandom_range(0, 65535));
      else if (roll < 20) r.lifetime = '0;
      else                r.lifetime = 16'($urandom_range(1, 300));
      roll = $urandom_range(0, 99);
      if (roll < 5)       r.elapse = 16'($urandom_range(0, 65535));
      else if (roll < 15) r.elapse = '0;
      else                r.elapse = 16'($urandom_range(0, 63));
      if (pick < 40)      r.mode = MODE_ADD;
      else if (pick < 65) r.mode = MODE_TICK;
      else if (pick < 97) r.mode = MODE_READ;
      else                r.mode = MODE_CLEAR;
      return r;
   endfunction

   task automatic send_item(input req_type r, input bit checked, input rsp_type want,
                            input int idle_pct);
      rsp_type guess;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer taken at this edge
      guess = predict_pool_rsp(r);
      rsp_due.insert(rsp_due.size(), checked ? want : guess);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (rsp_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            want_rsp = rsp_due.pop_front();
            if (rsp_data.accepted      !== want_rsp.accepted      ||
                rsp_data.slot_index    !== want_rsp.slot_index    ||
                rsp_data.any_active    !== want_rsp.any_active    ||
                rsp_data.read_active   !== want_rsp.read_active   ||
                rsp_data.read_x        !== want_rsp.read_x        ||
                rsp_data.read_y        !== want_rsp.read_y        ||
                rsp_data.read_z        !== want_rsp.read_z        ||
                rsp_data.read_radius   !== want_rsp.read_radius   ||
                rsp_data.read_elapsed  !== want_rsp.read_elapsed  ||
                rsp_data.read_lifetime !== want_rsp.read_lifetime) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("  expected acc=%0d idx=%0d any=%0d act=%0d x=%h y=%h z=%h",
                           want_rsp.accepted, want_rsp.slot_index, want_rsp.any_active,
                           want_rsp.read_active, want_rsp.read_x, want_rsp.read_y,
                           want_rsp.read_z);
                  $display("           rad=%h el=%h life=%h", want_rsp.read_radius,
                           want_rsp.read_elapsed, want_rsp.read_lifetime);
                  $display("  actual   acc=%0d idx=%0d any=%0d act=%0d x=%h y=%h z=%h",
                           rsp_data.accepted, rsp_data.slot_index, rsp_data.any_active,
                           rsp_data.read_active, rsp_data.read_x, rsp_data.read_y,
                           rsp_data.read_z);
                  $display("           rad=%h el=%h life=%h", rsp_data.read_radius,
                           rsp_data.read_elapsed, rsp_data.read_lifetime);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int phase_idle [3];
      int phase_len;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      refill_pool();

      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd0), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd31), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 16'h0000, 0), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_ADD, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'hffff, 0, 0),
                1, 1, mk_rsp(1, 5'd0, 1, 0, 0, 0, 0, 0, 0, 0));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd0), 1, 1,
                mk_rsp(0, 5'd0, 1, 1, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0000,
                       16'hffff));
      // zero lifetime: gone at the next tick even with no time passing
      plan_step(mk_req(MODE_ADD, 16'h0123, 16'hfedc, 16'h7fff, 16'h0000, 16'h0000, 0, 0),
                1, 1, mk_rsp(1, 5'd1, 1, 0, 0, 0, 0, 0, 0, 0));
      plan_step(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 16'h0000, 0), 1, 1, quiet_rsp(1));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd1), 1, 1, quiet_rsp(1));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd0), 1, 0, quiet_rsp(0));
      // age reaching its top value meets the largest lifetime
      plan_step(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 16'hffff, 0), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd0), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_ADD, 16'h1111, 16'h2222, 16'h3333, 16'h0180, 16'd100, 0, 0),
                1, 0, quiet_rsp(0));
      plan_step(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 16'h7fff, 0), 1, 0, quiet_rsp(0));
      plan_step(mk_req(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 1, quiet_rsp(0));
      // fill the pool, then an add must be refused
      plan_step(mk_req(MODE_ADD, 16'h0a00, 16'hf600, 16'h0100, 16'h0200, 16'd1000, 0, 0),
                SLOTS, 0, quiet_rsp(0));
      plan_step(mk_req(MODE_ADD, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'd10, 0, 0),
                1, 1, quiet_rsp(1));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd31), 1, 0, quiet_rsp(0));
      plan_step(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 16'd500, 0), 1, 1, quiet_rsp(1));
      plan_step(mk_req(MODE_TICK, 0, 0, 0, 0, 0, 16'd500, 0), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_ADD, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'd5, 0, 0),
                1, 0, quiet_rsp(0));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd0), 1, 0, quiet_rsp(0));
      plan_step(mk_req(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 1, quiet_rsp(0));
      plan_step(mk_req(MODE_READ, 0, 0, 0, 0, 0, 0, 5'd0), 1, 1, quiet_rsp(0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k])
         repeat (plan[k].reps) send_item(plan[k].item, plan[k].checked, plan[k].want, 35);

      phase_idle[0] = 35;
      phase_idle[1] = 68;
      phase_idle[2] = 0;
      for (int p = 0; p < 3; p++) begin
         // hold off until the pool has answered everything
         start <= 1'b0;
         while (rsp_due.size() != 0) @(posedge clock);
         phase_len = (p == 2) ? RAND_ITEMS - 2 * (RAND_ITEMS / 3) : RAND_ITEMS / 3;
         repeat (phase_len) send_item(rand_item(), 1'b0, quiet_rsp(0), phase_idle[p]);
      end

      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- timed_slot_pool_free_list.f -----
sv/tspfl_pkg.sv
sv/tspfl_ram.sv
sv/timed_slot_pool_free_list.sv
test/timed_slot_pool_free_list_tb.sv
